### sv/sha_pkg.sv
// package: shared types and constants for the sha-256 word stream hasher
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   // round constants
   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PadMark = 32'h80000000;

   // commands from controller to datapath
   typedef struct packed {
      logic load_word;     // store incoming word, bump count
      logic load_pad;      // write pad marker and zero fill
      logic clear_block;   // zero the block buffer
      logic load_length;   // write bit length into words 14 and 15
      logic start_comp;    // copy block into schedule, init working vars
      logic do_round;      // run one round
      logic finish_comp;   // add working vars into hash
      logic reset_msg;     // back to initial state
   } sha_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       block_full;  // 16 words held
      logic       pad_spill;   // more than 13 words held, needs extra block
      logic       last_round;  // round 63 running
   } sha_stat_type;

endpackage
`default_nettype wire

### sv/sha_datapath.sv
// datapath: block buffer, schedule window, round logic, hash state
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sha_pkg::sha_cmd_type cmd,
   input  wire logic [31:0]          word_in,
   input  wire logic [1:0]           part_sel,
   output sha_pkg::sha_stat_type     stat,
   output logic [63:0]               digest_part
);
   import sha_pkg::*;

   logic [31:0] hash_ff [8];
   logic [31:0] block_ff [16];
   logic [31:0] sched_ff [16];
   logic [31:0] work_ff [8];
   logic [4:0]  count_ff, count_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  round_ff, round_in;

   logic [31:0] be_word, w_cur, w_new, x15, x2, s0, s1, t1, t2;
   logic [31:0] a, b, c, d, e, f, g, h;
   logic [3:0]  ridx;

   assign be_word = {word_in[7:0], word_in[15:8], word_in[23:16], word_in[31:24]};
   assign ridx = round_ff[3:0];
   assign x15 = sched_ff[ridx + 4'd1];
   assign x2  = sched_ff[ridx + 4'd14];
   assign s0 = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
   assign s1 = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
   assign w_new = sched_ff[ridx] + s0 + sched_ff[ridx + 4'd9] + s1;
   assign w_cur = (round_ff >= 6'd16) ? w_new : sched_ff[ridx];
   assign {a, b, c, d, e, f, g, h} = {work_ff[0], work_ff[1], work_ff[2], work_ff[3],
                                      work_ff[4], work_ff[5], work_ff[6], work_ff[7]};
   assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & f) ^ (~e & g)) + RoundK[round_ff] + w_cur;
   assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & b) ^ (a & c) ^ (b & c));

   assign stat.block_full = count_ff[4];
   assign stat.pad_spill  = (count_ff[3:0] > 4'd13);
   assign stat.last_round = (round_ff == 6'd63);

   assign digest_part = {hash_ff[{part_sel, 1'b0}], hash_ff[{part_sel, 1'b1}]};

   always_comb begin
      count_in = count_ff;
      bits_in  = bits_ff;
      round_in = round_ff;
      if (cmd.load_word) begin
         count_in = count_ff + 5'd1;
         bits_in  = bits_ff + 64'd32;
      end
      if (cmd.start_comp) begin
         round_in = '0;
      end
      if (cmd.do_round) begin
         round_in = round_ff + 6'd1;
      end
      if (cmd.finish_comp) begin
         count_in = '0;
      end
      if (cmd.reset_msg) begin
         count_in = '0;
         bits_in  = '0;
         round_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
      end else begin
         count_ff <= count_in;
         bits_ff  <= bits_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.reset_msg) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= InitHash[i];
      end else if (cmd.finish_comp) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) block_ff[count_ff[3:0]] <= be_word;
      if (cmd.load_pad) begin
         for (int i = 0; i < 16; i++) begin
            if (i[4:0] == {1'b0, count_ff[3:0]}) block_ff[i] <= PadMark;
            else if (i[4:0] > {1'b0, count_ff[3:0]}) block_ff[i] <= '0;
         end
      end
      if (cmd.clear_block) begin
         for (int i = 0; i < 16; i++) block_ff[i] <= '0;
      end
      if (cmd.load_length) begin
         block_ff[14] <= bits_ff[63:32];
         block_ff[15] <= bits_ff[31:0];
      end
      if (cmd.start_comp) begin
         for (int i = 0; i < 16; i++) sched_ff[i] <= block_ff[i];
         for (int i = 0; i < 8; i++) work_ff[i] <= hash_ff[i];
      end
      if (cmd.do_round) begin
         sched_ff[ridx] <= w_cur;
         work_ff[0] <= t1 + t2;
         work_ff[1] <= a;
         work_ff[2] <= b;
         work_ff[3] <= c;
         work_ff[4] <= d + t1;
         work_ff[5] <= e;
         work_ff[6] <= f;
         work_ff[7] <= g;
      end
   end
endmodule
`default_nettype wire

### sv/sha_control.sv
// controller: sequences word loads, compressions, padding and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  word_present,
   input  wire logic                  final_item,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [1:0]                 part_sel,
   input  wire sha_pkg::sha_stat_type stat,
   output sha_pkg::sha_cmd_type       cmd
);
   import sha_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CHECK  = 8'b00000010,
      ST_ROUND  = 8'b00000100,
      ST_FINISH = 8'b00001000,
      ST_PAD    = 8'b00010000,
      ST_LENGTH = 8'b00100000,
      ST_OUT    = 8'b01000000,
      ST_START  = 8'b10000000
   } state_type;

   // phase of the current compression: 0 data block, 1 spill pad, 2 final length
   typedef enum logic [1:0] {
      PH_DATA  = 2'd0,
      PH_SPILL = 2'd1,
      PH_LAST  = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      final_ff, final_in;
   logic [1:0] part_ff, part_in;
   logic      take;

   assign req_tready = (state_ff == ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign part_sel   = part_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      final_in = final_ff;
      part_in  = part_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load_word = word_present;
               final_in      = final_item;
               if (word_present || final_item) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.block_full) begin
               phase_in = PH_DATA;
               state_in = ST_START;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.load_pad = 1'b1;
            if (stat.pad_spill) begin
               phase_in = PH_SPILL;
               state_in = ST_START;
            end else begin
               state_in = ST_LENGTH;
            end
         end
         ST_LENGTH: begin
            cmd.load_length = 1'b1;
            phase_in = PH_LAST;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.start_comp = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            if (stat.last_round) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish_comp = 1'b1;
            case (phase_ff)
               PH_DATA:  state_in = final_ff ? ST_PAD : ST_IDLE;
               PH_SPILL: begin
                  cmd.clear_block = 1'b1;
                  state_in = ST_LENGTH;
               end
               default: begin
                  part_in  = '0;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_tready) begin
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  cmd.reset_msg = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DATA;
         final_ff <= 1'b0;
         part_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         final_ff <= final_in;
         part_ff  <= part_in;
      end
   end
endmodule
`default_nettype wire

### sv/sha256_word_stream_hasher_top.sv
// top level: sha-256 hasher over a stream of 32-bit message words
`timescale 1ns / 1ps
`default_nettype none
// usage
//  - req channel: one transaction per message word; tdata = data_word, tuser =
//    word_present, tlast = final_item; each word's bytes taken low byte first
//  - a transaction with tlast set closes the message: padding and length
//    are appended and the digest follows on the rsp channel
//  - rsp channel: four transactions, tdata = digest_part (earlier hash word in
//    the upper half), tuser = part_index, tlast = last_part on the fourth
//  - a word that does not fill a block passes only through the check state; the 16th word
//    of a block adds a compression (one round per cycle in the shared round unit)
//  - final item: one or two compressions (two when 14 or 15 words are held, or when
//    its word fills a block) before the first digest transaction
//  - one item is in work at a time; req_tready is low until it completes
//  - if the receiver stalls, the digest part holds and the block waits
//  - reset returns the hash state to the initial values and drops any message
module sha256_word_stream_hasher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // data_word
   input  wire logic        req_tuser,   // word_present
   input  wire logic        req_tlast,   // final_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // digest_part
   output logic [1:0]       rsp_tuser,   // part_index
   output logic             rsp_tlast    // last_part
);
   import sha_pkg::*;

   sha_cmd_type  cmd;
   sha_stat_type stat;
   logic [1:0]   part_sel;

   sha_control u_control (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .word_present (req_tuser),
      .final_item   (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .part_sel     (part_sel),
      .stat         (stat),
      .cmd          (cmd)
   );

   sha_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .word_in     (req_tdata),
      .part_sel    (part_sel),
      .stat        (stat),
      .digest_part (rsp_tdata)
   );

   // part index straight from the controller's output counter
   assign rsp_tuser = part_sel;
   assign rsp_tlast = (part_sel == 2'd3);
endmodule
`default_nettype wire

### sv/sha_checker.sv
// checker: port-level properties of the hasher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   // a stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed under stall");

   // last flag matches the final quarter
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd3)))
      else $error("rsp_tlast inconsistent");

   // no input taken while digest is being sent
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready during output");

   // parts advance in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 2'd1)
      else $error("digest parts out of order");
endmodule

bind sha256_word_stream_hasher_top sha_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

### verif/sha256_word_stream_hasher_top_tb.sv
// testbench: streaming sha-256 hasher checked against a behavioral digest predictor
`timescale 1ns / 1ps
`default_nettype none
module sha256_word_stream_hasher_top_tb;
   import sha_pkg::*;

   typedef struct packed {
      logic [63:0] digest_part;
      logic [1:0]  part_index;
      logic        last_part;
   } digest_txn_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0; // word_present
   logic        req_tlast = 1'b0; // final_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // digest_part
   logic [1:0]  rsp_tuser;        // part_index
   logic        rsp_tlast;        // last_part

   int          error_count = 0;
   bit          idle_enable = 1'b1;
   digest_txn_t expected_digests[$];

   // predictor state
   logic [31:0] hash_state [8];
   logic [31:0] block_words [16];
   int unsigned held_words;
   logic [63:0] bit_length;

   sha256_word_stream_hasher_top DUT (.*);

   always #6 clock = ~clock;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic clear_message();
      hash_state = InitHash;
      for (int i = 0; i < 16; i++) block_words[i] = '0;
      held_words = 0;
      bit_length = '0;
   endtask

   task automatic compress();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 64; t++) begin
         if (t < 16) w[t] = block_words[t];
         else begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
         end
      end
      {a, b, c, d, e, f, g, h} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3],
                                  hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
      for (int t = 0; t < 64; t++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + RoundK[t] + w[t];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // advance the predictor by one accepted word item
   task automatic predict_digest(logic [31:0] word, logic present, logic final_mark);
      digest_txn_t part;
      if (present) begin
         block_words[held_words] = {word[7:0], word[15:8], word[23:16], word[31:24]};
         held_words++;
         bit_length += 64'd32;
         if (held_words == 16) begin
            compress();
            held_words = 0;
         end
      end
      if (final_mark) begin
         block_words[held_words] = PadMark;
         for (int i = held_words + 1; i < 16; i++) block_words[i] = '0;
         if (held_words > 13) begin
            compress();
            for (int i = 0; i < 16; i++) block_words[i] = '0;
         end
         block_words[14] = bit_length[63:32];
         block_words[15] = bit_length[31:0];
         compress();
         for (int k = 0; k < 4; k++) begin
            part.digest_part = {hash_state[2*k], hash_state[2*k+1]};
            part.part_index  = 2'(k);
            part.last_part   = (k == 3);
            expected_digests.push_back(part);
         end
         clear_message();
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("mismatch %s: got %h expected %h", what, got, want);
   endtask

   // sends one word transaction, sometimes with a random idle gap ahead of it
   task automatic send_word(logic [31:0] word, logic present, logic final_mark);
      if (idle_enable && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (idle_enable && $urandom_range(99) < 16) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= present;
      req_tlast  <= final_mark;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(word, present, final_mark);
   endtask

   task automatic send_message(int n, bit present_only);
      for (int i = 0; i < n; i++)
         send_word($urandom, present_only ? 1'b1 : 1'($urandom_range(9) != 0), 1'b0);
      send_word($urandom, 1'($urandom_range(1)), 1'b1);
   endtask

   // stop sending and wait until every expected digest has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : (!idle_enable || $urandom_range(99) >= 16);

   // digest checker
   always @(posedge clock) begin
      digest_txn_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) report_mismatch("unexpected", rsp_tdata, 64'd0);
         else begin
            want = expected_digests.pop_front();
            if (rsp_tdata !== want.digest_part)
               report_mismatch("digest_part", rsp_tdata, want.digest_part);
            if (rsp_tuser !== want.part_index)
               report_mismatch("part_index", 64'(rsp_tuser), 64'(want.part_index));
            if (rsp_tlast !== want.last_part)
               report_mismatch("last_part", 64'(rsp_tlast), 64'(want.last_part));
         end
      end
   end

   // empty message, empty items, extreme words, a padding spill case
   task automatic test_directed();
      send_word(32'h0, 1'b0, 1'b1);
      send_word(32'hffffffff, 1'b0, 1'b0);
      send_word(32'h0, 1'b0, 1'b0);
      send_word(32'h00000000, 1'b1, 1'b0);
      send_word(32'hffffffff, 1'b1, 1'b1);
      send_word(32'h80000001, 1'b1, 1'b1);
      for (int i = 0; i < 13; i++) send_word(32'h01020304 * i, 1'b1, 1'b0);
      send_word(32'hdeadbeef, 1'b1, 1'b1);
   endtask

   // block-boundary lengths around one and two full blocks
   task automatic test_block_boundaries();
      send_message(13, 1);
      send_message(14, 1);
      send_message(15, 1);
      send_message(16, 1);
      send_message(31, 1);
   endtask

   // random messages of mostly short length, with occasional empty items
   task automatic test_random_messages();
      int sent = 0;
      int n;
      while (sent < 300) begin
         n = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
         if (sent > 110 && sent < 200) idle_enable = 1'b0;
         else idle_enable = 1'b1;
         send_message(n, 0);
         sent += n + 1;
         if ($urandom_range(9) == 0) wait_drained();
      end
      idle_enable = 1'b1;
   endtask

   // an empty message sent after the hasher has drained should still hash correctly
   task automatic test_drain_then_empty();
      wait_drained();
      send_word($urandom, 1'b0, 1'b1);
   endtask

   initial begin
      clear_message();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_block_boundaries();
      test_random_messages();
      test_drain_then_empty();
      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_control.sv
sv/sha256_word_stream_hasher_top.sv
sv/sha_checker.sv
verif/sha256_word_stream_hasher_top_tb.sv
